>>> sv/sfb_pkg.sv
// Shared types and constants for the section framer with byte filter.
package sfb_pkg;

  localparam int FILTER_BYTES_DEF = 16;
  localparam int CFG_DATA_W       = 64;
  localparam int POS_W            = 13;
  localparam int LEN_W            = 12;
  localparam int CNT_W            = 32;
  localparam int FLEN_W           = 5;

  localparam logic [3:0]       LEN_NIBBLE_MASK = 4'hF;
  localparam logic [POS_W-1:0] HDR_OFFSET      = 13'd2;
  localparam logic [LEN_W-1:0] MAX_BODY_RESET  = 12'hFFF;

  typedef enum logic [2:0] {
    REG_FILTER_LO = 3'd0,
    REG_FILTER_HI = 3'd1,
    REG_MASK_LO   = 3'd2,
    REG_MASK_HI   = 3'd3,
    REG_FILT_LEN  = 3'd4,
    REG_MAX_BODY  = 3'd5,
    REG_SECT_LIM  = 3'd6,
    REG_MATCH_LIM = 3'd7
  } sfb_reg_t;

  typedef struct packed {
    logic [FLEN_W-1:0] filter_length;
    logic [LEN_W-1:0]  max_body_length;
    logic [CNT_W-1:0]  section_limit;
    logic [CNT_W-1:0]  match_limit;
  } sfb_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       section_end;
    logic       section_match;
    logic       length_error;
    logic       stopped;
  } sfb_result_t;

endpackage

>>> sv/section_framer_with_byte_filter.sv
// Top level: input register, section core, result register and config port.
//
//  channel  | direction | handshake         | payload
//  s_*      | in        | s_tvalid/s_tready | tdata: stream_byte
//  m_*      | out       | m_tvalid/m_tready | tdata: out_byte, tlast: section_end,
//           |           |                   | tuser: section_match, length_error, stopped
//  cfg_*    | in        | cfg_we            | cfg_index, cfg_data
//
// Each word passes the input register, then the section core into the result
// register. A new word is taken every cycle while the result side drains; the
// core updates its framing state once per word, which sets this.
// rst is synchronous; it clears the pipeline, the framing state and counters,
// and returns all configuration registers to their reset values.
// A stall on m_tready backs up through both
// registers to s_tready in the same cycle; no word is lost or repeated.
module section_framer_with_byte_filter
  import sfb_pkg::*;
#(
  parameter int FILTER_BYTES = FILTER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] stream_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] out_byte
  output logic                  m_tlast,
  output logic [2:0]            m_tuser,   // [0] section_match, [1] length_error, [2] stopped
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FILTER_BYTES-1:0][7:0] filter_bytes;
  logic [FILTER_BYTES-1:0][7:0] mask_bytes;
  sfb_cfg_t                     cfg;
  sfb_result_t                  result;
  logic                         halted;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       fire;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  sfb_cfg_regs #(.FILTER_BYTES(FILTER_BYTES)) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .filter_bytes (filter_bytes),
    .mask_bytes   (mask_bytes),
    .cfg          (cfg)
  );

  sfb_section_core #(.FILTER_BYTES(FILTER_BYTES)) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (fire),
    .in_byte      (in_byte),
    .filter_bytes (filter_bytes),
    .mask_bytes   (mask_bytes),
    .cfg          (cfg),
    .result       (result),
    .halted       (halted)
  );

  // Result register: load on each processed word, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= result.out_byte;
      m_tlast <= result.section_end;
      m_tuser <= {result.stopped, result.length_error, result.section_match};
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("stop flag cleared without reset");

  a_stopped_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (!m_tlast && m_tdata == 8'd0 && m_tuser[1:0] == 2'b00))
    else $error("dropped word carries data or flags");

  a_match_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tlast && !m_tuser[1]))
    else $error("match flag outside a clean section end");

  a_lerr_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("length error word does not end a frame");

  a_halt_drops: assert property (@(posedge clk) disable iff (rst)
    (fire && halted) |=> (m_tvalid && m_tuser[2]))
    else $error("word processed while stopped was not flagged");

endmodule

>>> sv/sfb_cfg_regs.sv
// Configuration register file: filter and mask bytes, lengths and limits.
module sfb_cfg_regs
  import sfb_pkg::*;
#(
  parameter int FILTER_BYTES = FILTER_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_data,
  output logic [FILTER_BYTES-1:0][7:0]       filter_bytes,
  output logic [FILTER_BYTES-1:0][7:0]       mask_bytes,
  output sfb_cfg_t                           cfg
);

  sfb_reg_t reg_sel;
  assign reg_sel = sfb_reg_t'(cfg_index);

  // Filter and mask bytes: byte k lives in the low word for k below 8.
  for (genvar k = 0; k < FILTER_BYTES; k++) begin : g_byte
    always_ff @(posedge clk) begin
      if (rst) begin
        filter_bytes[k] <= 8'd0;
        mask_bytes[k]   <= 8'd0;
      end else if (cfg_we) begin
        if (k < 8) begin
          if (reg_sel == REG_FILTER_LO) filter_bytes[k] <= cfg_data[8*(k%8) +: 8];
          if (reg_sel == REG_MASK_LO)   mask_bytes[k]   <= cfg_data[8*(k%8) +: 8];
        end else begin
          if (reg_sel == REG_FILTER_HI) filter_bytes[k] <= cfg_data[8*(k%8) +: 8];
          if (reg_sel == REG_MASK_HI)   mask_bytes[k]   <= cfg_data[8*(k%8) +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_length   <= '0;
      cfg.max_body_length <= MAX_BODY_RESET;
      cfg.section_limit   <= '0;
      cfg.match_limit     <= '0;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_FILT_LEN:  cfg.filter_length   <= cfg_data[FLEN_W-1:0];
        REG_MAX_BODY:  cfg.max_body_length <= cfg_data[LEN_W-1:0];
        REG_SECT_LIM:  cfg.section_limit   <= cfg_data[CNT_W-1:0];
        REG_MATCH_LIM: cfg.match_limit     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/sfb_section_core.sv
// Section framing state, masked filter compare, counters and stop logic.
module sfb_section_core
  import sfb_pkg::*;
#(
  parameter int FILTER_BYTES = FILTER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [7:0]                   in_byte,
  input  logic [FILTER_BYTES-1:0][7:0] filter_bytes,
  input  logic [FILTER_BYTES-1:0][7:0] mask_bytes,
  input  sfb_cfg_t                     cfg,
  output sfb_result_t                  result,
  output logic                         halted
);

  localparam int KW = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
  localparam logic [FLEN_W-1:0] FB_MAX = FLEN_W'(FILTER_BYTES);

  logic [3:0]       length_high_nibble;
  logic [LEN_W-1:0] body_length;
  logic [POS_W-1:0] byte_position;
  logic             match_so_far;
  logic [CNT_W-1:0] sections_seen;
  logic [CNT_W-1:0] sections_matched;

  logic [FLEN_W-1:0] act_len;
  logic [POS_W-1:0]  k_full;
  logic [KW-1:0]     k_idx;
  logic              cmp_hit;
  logic              mismatch;
  logic [LEN_W-1:0]  body_cur;
  logic              at_pos0, at_pos1, at_pos2;
  logic              lerr, sect_end, counted;
  logic              match_now, tail_miss, matched;
  logic [CNT_W-1:0]  seen_next, matched_next;
  logic              limit_hit;

  always_comb begin
    at_pos0 = (byte_position == '0);
    at_pos1 = (byte_position == POS_W'(1));
    at_pos2 = (byte_position == HDR_OFFSET);
    act_len = (cfg.filter_length > FB_MAX) ? FB_MAX : cfg.filter_length;

    // Filter byte 0 hits section byte 0, byte k hits section byte k+2.
    k_full  = at_pos0 ? '0 : byte_position - HDR_OFFSET;
    k_idx   = k_full[KW-1:0];
    cmp_hit = (at_pos0 || byte_position > HDR_OFFSET) && (k_full < POS_W'(act_len));
    mismatch = cmp_hit &&
               ((in_byte & mask_bytes[k_idx]) != (filter_bytes[k_idx] & mask_bytes[k_idx]));
    match_now = match_so_far && !mismatch;

    body_cur = at_pos2 ? {length_high_nibble, in_byte} : body_length;
    lerr     = at_pos2 && (body_cur > cfg.max_body_length);
    sect_end = !at_pos0 && !at_pos1 &&
               (lerr || byte_position >= POS_W'(body_cur) + HDR_OFFSET);
    counted  = sect_end && !lerr;

    // A filter position beyond the last section byte is a miss.
    tail_miss = (act_len != '0) && ((LEN_W'(act_len) - LEN_W'(1)) > body_cur);
    matched   = counted && match_now && !tail_miss;

    seen_next    = sections_seen + CNT_W'(1);
    matched_next = sections_matched + CNT_W'(matched);
    limit_hit = ((cfg.section_limit != '0) && (seen_next >= cfg.section_limit)) ||
                ((cfg.match_limit != '0) && (matched_next >= cfg.match_limit));

    if (halted) begin
      result = '{out_byte: 8'd0, section_end: 1'b0, section_match: 1'b0,
                 length_error: 1'b0, stopped: 1'b1};
    end else begin
      result = '{out_byte: in_byte, section_end: sect_end, section_match: matched,
                 length_error: lerr, stopped: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_high_nibble <= '0;
      body_length        <= '0;
      byte_position      <= '0;
      match_so_far       <= 1'b1;
      sections_seen      <= '0;
      sections_matched   <= '0;
      halted             <= 1'b0;
    end else if (step && !halted) begin
      if (at_pos0) begin
        match_so_far  <= match_now;
        byte_position <= POS_W'(1);
      end else if (at_pos1) begin
        length_high_nibble <= in_byte[3:0] & LEN_NIBBLE_MASK;
        byte_position      <= HDR_OFFSET;
      end else begin
        if (at_pos2) body_length <= body_cur;
        if (sect_end) begin
          byte_position <= '0;
          match_so_far  <= 1'b1;
        end else begin
          byte_position <= byte_position + POS_W'(1);
          match_so_far  <= match_now;
        end
        if (counted) begin
          sections_seen    <= seen_next;
          sections_matched <= matched_next;
          if (limit_hit) halted <= 1'b1;
        end
      end
    end
  end

endmodule

>>> test/tb_section_framer_with_byte_filter.sv
`timescale 1ns / 100ps
// Self-checking bench for the section framer: framed byte streams against a local predictor.
module tb_section_framer_with_byte_filter;
  import sfb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [3:0]  hi_nib;
    logic [11:0] body_len;
    logic [12:0] pos;
    logic        match_ok;
    logic [31:0] seen;
    logic [31:0] matched;
    logic        halted;
  } framer_state_t;

  typedef struct packed {
    framer_state_t st;
    sfb_result_t   res;
  } framer_step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic [2:0]            m_tuser;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_index = 3'd0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies as last written
  logic [63:0] flt_lo, flt_hi, msk_lo, msk_hi;
  logic [4:0]  flt_len;
  logic [11:0] max_body;
  logic [31:0] sect_lim, match_lim;

  framer_state_t line_st;  // advanced on each accepted word
  framer_state_t plan_st;  // advanced as words are queued

  logic [7:0]  stream_backlog[$];
  sfb_result_t results_due[$];
  int words_queued, words_in, words_out, last_in;
  int errors, cycles;
  int n_ends, n_hits, n_lerr, n_dropped;
  int send_gap, stall_left;
  bit send_calm, sink_calm;

  section_framer_with_byte_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] table_byte(logic [63:0] lo, logic [63:0] hi, int k);
    return (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
  endfunction

  function automatic int active_len();
    return (flt_len > FILTER_BYTES_DEF) ? FILTER_BYTES_DEF : int'(flt_len);
  endfunction

  function automatic bit byte_agrees(int k, logic [7:0] b);
    logic [7:0] f, m;
    if (k >= active_len()) return 1'b1;
    f = table_byte(flt_lo, flt_hi, k);
    m = table_byte(msk_lo, msk_hi, k);
    return (b & m) == (f & m);
  endfunction

  function automatic framer_step_t frame_step(framer_state_t s, logic [7:0] b);
    framer_step_t o;
    int n;
    bit fin, err, hit;
    o.st = s;
    o.res = '0;
    if (s.halted) begin
      o.res.stopped = 1'b1;
      return o;
    end
    n = active_len();
    fin = 1'b0;
    err = 1'b0;
    hit = 1'b0;
    if (s.pos == 13'd0) begin
      if (!byte_agrees(0, b)) o.st.match_ok = 1'b0;
      o.st.pos = 13'd1;
    end else if (s.pos == 13'd1) begin
      o.st.hi_nib = b[3:0];
      o.st.pos = 13'd2;
    end else begin
      if (s.pos == 13'd2) begin
        o.st.body_len = {s.hi_nib, b};
        if (o.st.body_len > max_body) begin
          err = 1'b1;
          fin = 1'b1;
        end
      end else if (!byte_agrees(int'(s.pos) - 2, b)) begin
        o.st.match_ok = 1'b0;
      end
      if (!err && int'(s.pos) >= int'(o.st.body_len) + 2) fin = 1'b1;
      if (fin && !err) begin
        // a filter reaching past the last byte cannot match
        hit = o.st.match_ok && !(n > 0 && n - 1 > int'(o.st.body_len));
        o.st.seen = s.seen + 32'd1;
        if (hit) o.st.matched = s.matched + 32'd1;
        if (sect_lim != 0 && o.st.seen >= sect_lim) o.st.halted = 1'b1;
        if (match_lim != 0 && o.st.matched >= match_lim) o.st.halted = 1'b1;
      end
      if (fin) begin
        o.st.pos = 13'd0;
        o.st.match_ok = 1'b1;
      end else begin
        o.st.pos = s.pos + 13'd1;
      end
    end
    o.res.out_byte = b;
    o.res.section_end = fin;
    o.res.section_match = hit;
    o.res.length_error = err;
    return o;
  endfunction

  // random byte that passes filter position k under its mask
  function automatic logic [7:0] fitted_byte(int k);
    logic [7:0] f, m, r;
    r = 8'($urandom);
    if (k >= active_len()) return r;
    f = table_byte(flt_lo, flt_hi, k);
    m = table_byte(msk_lo, msk_hi, k);
    return (f & m) | (r & ~m);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_len(int cap);
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(0, (cap < 20) ? cap : 20);
    if (r < 95) return $urandom_range(0, (cap < 80) ? cap : 80);
    return $urandom_range(0, (cap < 300) ? cap : 300);
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("MISMATCH word %0d %s: got %0h want %0h", words_out, what, got, want);
  endtask

  task automatic push_word(logic [7:0] b);
    framer_step_t nx;
    nx = frame_step(plan_st, b);
    plan_st = nx.st;
    stream_backlog.push_back(b);
    words_queued++;
  endtask

  task automatic queue_section(int len, bit aim);
    logic [11:0] l12;
    l12 = 12'(len);
    push_word(aim ? fitted_byte(0) : 8'($urandom));
    push_word({4'($urandom), l12[11:8]});
    push_word(l12[7:0]);
    // an oversized header frames alone; the body would start a new section
    if (l12 <= max_body)
      for (int j = 1; j <= len; j++) push_word(aim ? fitted_byte(j) : 8'($urandom));
  endtask

  task automatic fill_phase(int budget, int aim_pct, int noise_pct, int err_pct);
    int start, r;
    start = words_queued;
    plan_st = line_st;
    while (words_queued - start < budget) begin
      r = $urandom_range(99);
      if (r < noise_pct) begin
        repeat ($urandom_range(1, 8)) push_word(8'($urandom));
        // pad out whatever frame the noise opened
        while (plan_st.pos != 13'd0 && !plan_st.halted) push_word(8'($urandom));
      end else if (r < noise_pct + err_pct && max_body < MAX_BODY_RESET) begin
        queue_section($urandom_range(int'(max_body) + 1, 4095), 1'b0);
      end else begin
        queue_section(pick_len(int'(max_body)), $urandom_range(99) < aim_pct);
      end
    end
  endtask

  task automatic drain();
    while (words_in != words_queued || results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(sfb_reg_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_FILTER_LO: flt_lo = v;
      REG_FILTER_HI: flt_hi = v;
      REG_MASK_LO:   msk_lo = v;
      REG_MASK_HI:   msk_hi = v;
      REG_FILT_LEN:  flt_len = v[4:0];
      REG_MAX_BODY:  max_body = v[11:0];
      REG_SECT_LIM:  sect_lim = v[31:0];
      REG_MATCH_LIM: match_lim = v[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin : feed
    logic       nv;
    logic [7:0] nd;
    nv = s_tvalid;
    nd = s_tdata;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (words_in != last_in) begin
        last_in = words_in;
        nv = 1'b0;
        if ($urandom_range(49) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : pick_gap();
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stream_backlog.size() != 0) begin
          nd = stream_backlog.pop_front();
          nv = 1'b1;
        end
      end
    end
    s_tvalid <= nv;
    s_tdata <= nd;
  end

  always @(negedge clk) begin : sink
    if (rst) begin
      m_tready <= 1'b1;
    end else begin
      if ($urandom_range(99) == 0) sink_calm = !sink_calm;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!sink_calm && $urandom_range(99) < 25) begin
        stall_left = ($urandom_range(99) < 85) ? $urandom_range(0, 2) : $urandom_range(7, 39);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch
    sfb_result_t  got, want;
    framer_step_t nx;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d words still due", cycles, results_due.size());
      $display("section_framer_with_byte_filter verification failed");
      $finish;
    end else if (!rst) begin
      if (s_tvalid && s_tready) begin
        nx = frame_step(line_st, s_tdata);
        line_st = nx.st;
        results_due.push_back(nx.res);
        words_in++;
        n_ends += int'(nx.res.section_end);
        n_hits += int'(nx.res.section_match);
        n_lerr += int'(nx.res.length_error);
        n_dropped += int'(nx.res.stopped);
      end
      if (m_tvalid && m_tready) begin
        got.out_byte = m_tdata;
        got.section_end = m_tlast;
        got.section_match = m_tuser[0];
        got.length_error = m_tuser[1];
        got.stopped = m_tuser[2];
        if (results_due.size() == 0) begin
          report("arrived with nothing due", int'(got), 0);
        end else begin
          want = results_due.pop_front();
          if (got.out_byte != want.out_byte)
            report("out_byte", int'(got.out_byte), int'(want.out_byte));
          if (got.section_end != want.section_end)
            report("section_end", int'(got.section_end), int'(want.section_end));
          if (got.section_match != want.section_match)
            report("section_match", int'(got.section_match), int'(want.section_match));
          if (got.length_error != want.length_error)
            report("length_error", int'(got.length_error), int'(want.length_error));
          if (got.stopped != want.stopped)
            report("stopped", int'(got.stopped), int'(want.stopped));
        end
        words_out++;
      end
    end
  end

  initial begin : stim
    logic [7:0] opening [15];
    logic [7:0] closing [8];
    int lim;
    // matching section; filter past a short end; empty section
    opening = '{8'h42, 8'hF0, 8'h05, 8'h1A, 8'h22, 8'h33, 8'h00, 8'hFF,
                8'h42, 8'h00, 8'h01, 8'h11,
                8'hFF, 8'h30, 8'h00};
    // oversized header alone, then a short section under a clamped filter length
    closing = '{8'h00, 8'h0F, 8'hFF, 8'hAB, 8'h00, 8'h02, 8'h55, 8'hAA};
    flt_lo = '0;
    flt_hi = '0;
    msk_lo = '0;
    msk_hi = '0;
    flt_len = '0;
    max_body = MAX_BODY_RESET;
    sect_lim = '0;
    match_lim = '0;
    line_st = '0;
    line_st.match_ok = 1'b1;
    plan_st = line_st;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_FILTER_LO, 64'hFFFF_FFFF_3322_1142);
    write_reg(REG_FILTER_HI, 64'h0);
    write_reg(REG_MASK_LO, 64'h0000_0000_FFFF_F0FF);
    write_reg(REG_MASK_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_FILT_LEN, 64'd4);
    write_reg(REG_MAX_BODY, 64'd4095);
    write_reg(REG_SECT_LIM, 64'd0);
    write_reg(REG_MATCH_LIM, 64'd0);
    plan_st = line_st;
    foreach (opening[i]) push_word(opening[i]);
    drain();

    write_reg(REG_MAX_BODY, 64'd2);
    write_reg(REG_FILT_LEN, 64'd31);
    plan_st = line_st;
    foreach (closing[i]) push_word(closing[i]);
    drain();

    // no filter: every section passes
    write_reg(REG_FILTER_LO, {$urandom, $urandom});
    write_reg(REG_FILTER_HI, {$urandom, $urandom});
    write_reg(REG_MASK_LO, {$urandom, $urandom});
    write_reg(REG_FILT_LEN, 64'd0);
    write_reg(REG_MAX_BODY, 64'd4095);
    fill_phase(50, 50, 0, 0);
    drain();

    // full-width filter over sections of mixed length
    write_reg(REG_MASK_HI, {$urandom, $urandom});
    write_reg(REG_FILT_LEN, 64'd16);
    fill_phase(80, 70, 0, 0);
    drain();

    // zero body limit: every header with a nonzero length overflows
    write_reg(REG_MAX_BODY, 64'd0);
    write_reg(REG_FILT_LEN, 64'd1);
    fill_phase(40, 50, 20, 40);
    drain();

    write_reg(REG_MAX_BODY, 64'($urandom_range(10, 40)));
    write_reg(REG_FILT_LEN, 64'($urandom_range(1, 15)));
    write_reg(REG_MASK_LO, {$urandom, $urandom} | 64'hFF00_00FF_0000_FF00);
    write_reg(REG_FILTER_LO, {$urandom, $urandom});
    fill_phase(170, 60, 25, 15);
    drain();

    // filter length above the filter size, limits far out of reach
    write_reg(REG_FILT_LEN, 64'($urandom_range(17, 31)));
    write_reg(REG_MAX_BODY, 64'd4095);
    write_reg(REG_SECT_LIM, 64'hFFFF_FFFF);
    write_reg(REG_MATCH_LIM, 64'hFFFF_FFFF);
    write_reg(REG_FILTER_HI, {$urandom, $urandom});
    fill_phase(70, 60, 0, 0);
    drain();

    // drop the match limit under the count: next section end stops the framer
    lim = int'(line_st.matched / 2);
    if (lim == 0) lim = 1;
    write_reg(REG_MATCH_LIM, 64'(lim));
    write_reg(REG_FILT_LEN, 64'd0);
    fill_phase(40, 100, 0, 0);
    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d words: %0d section ends, %0d matched, %0d length errors",
             words_in, n_ends, n_hits, n_lerr);
    $display("%0d words dropped after the stop, %0d cycles, %0d mismatches",
             n_dropped, cycles, errors);
    if (errors == 0) begin
      $display("section_framer_with_byte_filter verification clean");
    end else begin
      $display("section_framer_with_byte_filter verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sfb_pkg.sv
sv/sfb_cfg_regs.sv
sv/sfb_section_core.sv
sv/section_framer_with_byte_filter.sv
test/tb_section_framer_with_byte_filter.sv
